// ===== hdl/krsd_pkg.sv =====
// krsd_pkg: types and codes shared by the keyed reading store
// holds transaction payload structs, the slot entry layout and command codes
// no dependencies
package krsd_pkg;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_DUMP  = 1'b1;

   typedef struct packed {
      logic               command;
      logic [7:0]         key;
      logic signed [31:0] value;
      logic [31:0]        time_now;
   } req_item_type;

   typedef struct packed {
      logic [7:0]         out_key;
      logic signed [31:0] out_value;
      logic [31:0]        out_time;
      logic               is_last;
      logic               is_empty;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]         key;
      logic signed [31:0] value;
      logic [31:0]        stamp;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

// ===== hdl/krsd_ram.sv =====
// krsd_ram: generic single write port, single read port ram
// registered read data held while no read is issued
// no dependencies
module krsd_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/keyed_reading_store_with_dump.sv =====
// Keyed reading store: DEPTH slots of {key, value, time} in one ram with registered
// read, valid bits in flip-flops. One transaction is worked at a time and req_stall is
// high until it is done. A store walks the slots below the effective capacity one at a
// time through the ram read port: a free slot is noted, a held slot is read and compared
// while no match is found yet and passed over once a match is found; then the walk ends
// (S_SWR writes) and the store returns to S_IDLE, which accepts requests. A dump walks
// all DEPTH slots: a free slot is passed over, a held slot is read and cleared, and a
// closing step sends the last result; a stalled result side holds the dump. The result
// register lets the next request be accepted while the last result still waits. No
// clearing pass is needed after reset.
// depends on krsd_pkg and krsd_ram
module keyed_reading_store_with_dump #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  krsd_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output krsd_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  logic [4:0]            csr_wr_data
);

   import krsd_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CAPW = (CW > 5) ? CW : 5;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SRD   = 6'b000010,
      S_SCMP  = 6'b000100,
      S_SWR   = 6'b001000,
      S_DSEEK = 6'b010000,
      S_DREAD = 6'b100000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  match_ff, match_in;
   logic           match_found_ff, match_found_in;
   logic [AW-1:0]  free_ff, free_in;
   logic           free_found_ff, free_found_in;
   slot_entry_type pend_ff, pend_in;
   logic           pend_valid_ff, pend_valid_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [4:0]     cap_ff, cap_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   req_item_type   item_ff, item_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff, rsp_item_in;

   logic           out_free;
   logic [AW-1:0]  idx_a;
   logic [CW-1:0]  eff_cap;
   logic           ram_wr_en, ram_rd_en;
   logic [AW-1:0]  ram_wr_addr, ram_rd_addr;
   slot_entry_type ram_wr_entry, rd_entry;
   logic [ENTRY_W-1:0] ram_rd_data;

   krsd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = slot_entry_type'(ram_rd_data);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_a    = idx_ff[AW-1:0];

   // capacity clamped to 1..DEPTH
   always_comb begin
      priority if (cap_ff == 5'd0) begin
         eff_cap = CW'(1);
      end else if (CAPW'(cap_ff) > CAPW'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      match_in       = match_ff;
      match_found_in = match_found_ff;
      free_in        = free_ff;
      free_found_in  = free_found_ff;
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      count_in       = count_ff;
      cap_in         = cap_ff;
      valid_in       = valid_ff;
      item_in        = item_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_item_in    = rsp_item_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = free_ff;
      ram_wr_entry   = '{key: item_ff.key, value: item_ff.value, stamp: item_ff.time_now};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_a;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in        = req_item;
               idx_in         = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               pend_valid_in  = 1'b0;
               state_in       = (req_item.command == CMD_DUMP) ? S_DSEEK : S_SRD;
            end
         end
         S_SRD: begin
            priority if (idx_ff == eff_cap) begin
               state_in = S_SWR;
            end else if (valid_ff[idx_a]) begin
               if (!match_found_ff) begin
                  ram_rd_en = 1'b1;
                  state_in  = S_SCMP;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               if (!free_found_ff) begin
                  free_in       = idx_a;
                  free_found_in = 1'b1;
               end
               idx_in = idx_ff + CW'(1);
            end
         end
         S_SCMP: begin
            if (rd_entry.key == item_ff.key) begin
               match_in       = idx_a;
               match_found_in = 1'b1;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = S_SRD;
         end
         S_SWR: begin
            if (!match_found_ff || (count_ff < eff_cap)) begin
               if (free_found_ff) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_addr       = free_ff;
                  valid_in[free_ff] = 1'b1;
                  count_in          = count_ff + CW'(1);
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = match_ff;
            end
            state_in = S_IDLE;
         end
         S_DSEEK: begin
            priority if (idx_ff == CW'(DEPTH)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_item_in = '{out_key: pend_ff.key, out_value: pend_ff.value,
                                     out_time: pend_ff.stamp, is_last: 1'b1,
                                     is_empty: 1'b0};
                  end else begin
                     rsp_item_in = '{out_key: '0, out_value: '0, out_time: '0,
                                     is_last: 1'b1, is_empty: 1'b1};
                  end
                  pend_valid_in = 1'b0;
                  count_in      = '0;
                  state_in      = S_IDLE;
               end
            end else if (valid_ff[idx_a]) begin
               ram_rd_en       = 1'b1;
               valid_in[idx_a] = 1'b0;
               state_in        = S_DREAD;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_DREAD: begin
            // the held entry goes out only once a later one proves it is not the last
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = '{out_key: pend_ff.key, out_value: pend_ff.value,
                                   out_time: pend_ff.stamp, is_last: 1'b0,
                                   is_empty: 1'b0};
               end
               pend_in       = rd_entry;
               pend_valid_in = 1'b1;
               idx_in        = idx_ff + CW'(1);
               state_in      = S_DSEEK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         idx_ff         <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         pend_valid_ff  <= 1'b0;
         count_ff       <= '0;
         cap_ff         <= 5'd16;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         pend_valid_ff  <= pend_valid_in;
         count_ff       <= count_in;
         cap_ff         <= cap_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff    <= match_in;
      free_ff     <= free_in;
      pend_ff     <= pend_in;
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_ff) == int'(count_ff)))
      else $error("entry count disagrees with valid bits");

   a_dump_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DSEEK && state_in == S_IDLE) |=> (valid_ff == '0 && count_ff == '0))
      else $error("table not empty after dump");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.is_empty) |-> rsp_item_ff.is_last)
      else $error("empty result not marked last");

   a_pending_only_in_dump: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == S_DSEEK || state_ff == S_DREAD))
      else $error("held dump entry outside a dump");
`endif

endmodule

// ===== tb/tb_keyed_reading_store_with_dump.sv =====
// tb_keyed_reading_store_with_dump: self-checking bench for the keyed reading store
// drives store and dump transactions, predicts dump results from a local copy of the table
// depends on krsd_pkg and keyed_reading_store_with_dump
module tb_keyed_reading_store_with_dump;
   timeunit 1ns;
   timeprecision 1ps;

   import krsd_pkg::*;

   localparam int DEPTH         = 16;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en = 1'b0;
   logic [4:0]   csr_wr_data = '0;

   req_item_type pending_readings[$];
   rsp_item_type expected_dump[$];
   int           queued_count = 0;
   int           accepted_count = 0;
   int           failures = 0;
   int           send_idle_pct = 0;
   int           rcv_stall_pct = 0;
   int           hold_requests = 0;
   int           hold_served = 0;
   int           hold_left = 0;

   // local copy of the table
   logic              table_held [DEPTH];
   logic [7:0]        table_key  [DEPTH];
   logic signed [31:0] table_value[DEPTH];
   logic [31:0]       table_stamp[DEPTH];
   int                table_count;
   logic [4:0]        table_capacity;

   keyed_reading_store_with_dump #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic store_or_dump(input req_item_type it);
      int           cap;
      int           match;
      int           free_slot;
      int           last_held;
      rsp_item_type r;
      cap = (table_capacity < 1) ? 1 : (table_capacity > DEPTH) ? DEPTH : table_capacity;
      if (it.command == CMD_DUMP) begin
         last_held = -1;
         for (int i = 0; i < DEPTH; i++)
            if (table_held[i]) last_held = i;
         if (last_held < 0) begin
            r = '0;
            r.is_last = 1'b1;
            r.is_empty = 1'b1;
            expected_dump.push_back(r);
         end else begin
            // the dump walks every slot, even those above the capacity
            for (int i = 0; i < DEPTH; i++) begin
               if (table_held[i]) begin
                  r.out_key   = table_key[i];
                  r.out_value = table_value[i];
                  r.out_time  = table_stamp[i];
                  r.is_last   = (i == last_held);
                  r.is_empty  = 1'b0;
                  expected_dump.push_back(r);
                  table_held[i] = 1'b0;
               end
            end
         end
         table_count = 0;
      end else begin
         match = -1;
         free_slot = -1;
         for (int i = 0; i < cap; i++) begin
            if (table_held[i]) begin
               if (match < 0 && table_key[i] == it.key) match = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (match < 0 || table_count < cap) begin
            if (free_slot >= 0) begin
               table_held[free_slot]  = 1'b1;
               table_key[free_slot]   = it.key;
               table_value[free_slot] = it.value;
               table_stamp[free_slot] = it.time_now;
               table_count++;
            end
         end else begin
            table_key[match]   = it.key;
            table_value[match] = it.value;
            table_stamp[match] = it.time_now;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h got %h", $time, name, want, got);
         failures++;
      end
   endtask

   // driver: next reading goes out once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_item  <= pending_readings.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   // monitor: predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) table_held[i] = 1'b0;
         table_count = 0;
         table_capacity = 5'd16;
      end else begin
         if (csr_wr_en) table_capacity = csr_wr_data;
         if (req_valid && !req_stall) begin
            store_or_dump(req_item);
            accepted_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_dump.size() == 0) begin
               $display("%0t ns: unexpected result, got %h", $time, rsp_item);
               failures++;
            end else begin
               want = expected_dump.pop_front();
               check_field("out_key", 32'(want.out_key), 32'(rsp_item.out_key));
               check_field("out_value", want.out_value, rsp_item.out_value);
               check_field("out_time", want.out_time, rsp_item.out_time);
               check_field("is_last", 32'(want.is_last), 32'(rsp_item.is_last));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_item.is_empty));
            end
         end
      end
   end

   function automatic req_item_type reading(input logic cmd, input logic [7:0] k,
                                            input logic [31:0] v, input logic [31:0] t);
      req_item_type it;
      it.command  = cmd;
      it.key      = k;
      it.value    = v;
      it.time_now = t;
      return it;
   endfunction

   function automatic req_item_type random_reading();
      logic [7:0] k;
      // mostly a small key set so that matches and overwrites happen
      k = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(11));
      return reading(($urandom_range(9) == 0) ? CMD_DUMP : CMD_STORE, k, $urandom, $urandom);
   endfunction

   task automatic queue_item(input req_item_type it);
      pending_readings.push_back(it);
      queued_count++;
   endtask

   // all taken, all results back, and any store still being worked has finished
   task automatic wait_drained();
      while (accepted_count != queued_count || expected_dump.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [4:0] cap);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(input logic [4:0] cap, input int idle_pct, input int stall_pct,
                               input int count, input bit hold_off);
      set_capacity(cap);
      send_idle_pct = idle_pct;
      rcv_stall_pct = stall_pct;
      if (hold_off) hold_requests++;
      repeat (count) queue_item(random_reading());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty dump, field extremes, duplicate key below capacity
      queue_item(reading(CMD_DUMP, 8'h00, 32'h0, 32'h0));
      queue_item(reading(CMD_STORE, 8'h00, 32'h8000_0000, 32'h0000_0000));
      queue_item(reading(CMD_STORE, 8'hff, 32'h7fff_ffff, 32'hffff_ffff));
      queue_item(reading(CMD_STORE, 8'h00, 32'hffff_ffff, 32'h1234_5678));
      queue_item(reading(CMD_DUMP, 8'hff, 32'hffff_ffff, 32'hffff_ffff));

      // capacity zero acts as one: overwrite on a full table, drop of a new key
      set_capacity(5'd0);
      queue_item(reading(CMD_STORE, 8'h05, 32'h0000_0001, 32'h0000_0010));
      queue_item(reading(CMD_STORE, 8'h05, 32'hffff_fffe, 32'h0000_0020));
      queue_item(reading(CMD_STORE, 8'h06, 32'h0000_0003, 32'h0000_0030));
      queue_item(reading(CMD_DUMP, 8'h00, 32'h0, 32'h0));

      // capacity above the table acts as the full table, then lowered with entries held
      set_capacity(5'd31);
      queue_item(reading(CMD_STORE, 8'h01, 32'h0000_0101, 32'h0000_0001));
      queue_item(reading(CMD_STORE, 8'h02, 32'h0000_0202, 32'h0000_0002));
      queue_item(reading(CMD_STORE, 8'h03, 32'h0000_0303, 32'h0000_0003));
      set_capacity(5'd2);
      queue_item(reading(CMD_STORE, 8'h09, 32'h0000_0909, 32'h0000_0004));
      queue_item(reading(CMD_STORE, 8'h01, 32'h0000_0111, 32'h0000_0005));
      queue_item(reading(CMD_DUMP, 8'h00, 32'h0, 32'h0));

      random_phase(5'd16, 0, 0, 50, 1'b0);
      random_phase(5'd4, 78, 0, 50, 1'b0);
      random_phase(5'd1, 0, 78, 40, 1'b0);
      random_phase(5'd16, 21, 21, 50, 1'b0);
      // long hold-off on the result side while requests keep coming
      random_phase(5'd9, 0, 0, 40, 1'b1);
      random_phase(5'd7, 0, 0, 30, 1'b0);
      queue_item(reading(CMD_DUMP, 8'h00, 32'h0, 32'h0));
      wait_drained();

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/krsd_pkg.sv
hdl/krsd_ram.sv
hdl/keyed_reading_store_with_dump.sv
tb/tb_keyed_reading_store_with_dump.sv
